[src/cpm_pkg.sv]
// cpm_pkg: shared types and constants of the chunk pattern matcher
// no dependencies; used by the interfaces, the lanes, the merge stage and the top level
package cpm_pkg;

    localparam int TEXT_W = 64;
    localparam int ROW_W  = 32;
    localparam int MASK_W = 8;
    localparam int LEN_W  = 5;
    localparam int DATA_W = 64;
    localparam int IDX_W  = 2;
    localparam int WORD_BYTES = 8;

    typedef logic [7:0] cpm_byte_t;

    typedef enum logic [IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_PATTERN_LOW    = 2'd1,
        CFG_PATTERN_HIGH   = 2'd2
    } cpm_cfg_index_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             eop;
    } cpm_pass_t;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [ROW_W-1:0]  row;
        logic              eop;
    } cpm_entry_t;

endpackage

[src/cpm_chunk_if.sv]
// cpm_chunk_if: valid/ready channel carrying one text chunk
// depends on cpm_pkg
interface cpm_chunk_if;
    logic                         valid;
    logic                         ready;
    logic [cpm_pkg::TEXT_W-1:0]   text_bytes;
    logic [cpm_pkg::ROW_W-1:0]    row_number;
    logic                         end_of_packet;

    modport source (output valid, output text_bytes, output row_number,
                    output end_of_packet, input ready);
    modport sink   (input valid, input text_bytes, input row_number,
                    input end_of_packet, output ready);
endinterface

[src/cpm_result_if.sv]
// cpm_result_if: valid/ready channel carrying one match result
// depends on cpm_pkg
interface cpm_result_if;
    logic                         valid;
    logic                         ready;
    logic [cpm_pkg::MASK_W-1:0]   match_mask;
    logic [cpm_pkg::ROW_W-1:0]    row_out;
    logic                         packet_end_out;

    modport source (output valid, output match_mask, output row_out,
                    output packet_end_out, input ready);
    modport sink   (input valid, input match_mask, input row_out,
                    input packet_end_out, output ready);
endinterface

[src/cpm_lane.sv]
// cpm_lane: compares the pattern against the chunk at one fixed start offset
// depends on cpm_pkg
module cpm_lane #(
    parameter int LANE        = 0,
    parameter int CHUNK_BYTES = 8,
    parameter int MAX_PATTERN = 16
) (
    input  logic [cpm_pkg::TEXT_W-1:0] text_bytes,
    input  cpm_pkg::cpm_byte_t         pattern [MAX_PATTERN],
    input  logic [cpm_pkg::LEN_W-1:0]  length,
    output logic                       hit
);

    always_comb
    begin
        int          k;
        logic [2:0]  k3;
        logic        all_eq;
        logic        fits;
        all_eq = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            k  = LANE + j;
            k3 = k[2:0];
            if (cpm_pkg::LEN_W'(j) < length)
            begin
                if (k >= CHUNK_BYTES)
                    all_eq = 1'b0;
                else if (text_bytes[{k3, 3'b000} +: 8] != pattern[j])
                    all_eq = 1'b0;
            end
        end
        fits = ({1'b0, length} + 6'(LANE)) <= 6'(CHUNK_BYTES);
        hit  = (length != '0) && fits && all_eq;
    end

endmodule

[src/cpm_merge.sv]
// cpm_merge: packs the lane hits into the match mask and holds results in an
// output register with a skid entry; depends on cpm_pkg and cpm_result_if
module cpm_merge #(
    parameter int CHUNK_BYTES = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [CHUNK_BYTES-1:0] hits,
    input  cpm_pkg::cpm_pass_t     pass,
    input  logic                   take,
    output logic                   room,
    cpm_result_if.source           result
);

    cpm_pkg::cpm_entry_t incoming;
    cpm_pkg::cpm_entry_t out_reg, out_next;
    cpm_pkg::cpm_entry_t skid_reg, skid_next;
    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;

    always_comb
    begin
        incoming.mask = '0;
        incoming.mask[CHUNK_BYTES-1:0] = hits;
        incoming.row  = pass.row;
        incoming.eop  = pass.eop;
    end

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || result.ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = incoming;
                out_valid_next = take;
            end
        end
        else if (take)
        begin
            skid_next       = incoming;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign room                  = !skid_valid_reg;
    assign result.valid          = out_valid_reg;
    assign result.match_mask     = out_reg.mask;
    assign result.row_out        = out_reg.row;
    assign result.packet_end_out = out_reg.eop;

endmodule

[src/chunk_pattern_match.sv]
// chunk_pattern_match: top level of the multi-offset chunk pattern matcher
// depends on cpm_pkg, cpm_chunk_if, cpm_result_if, cpm_lane and cpm_merge
//
// usage
//   chunk:  valid/ready sink; one transfer carries eight text bytes, a row
//           index and an end-of-packet mark
//   result: valid/ready source; one transfer per chunk, in order, with a bit
//           per start offset where the whole pattern fits and matches
//   write port: write_enable, write_index (0 length, 1 bytes 0-7,
//           2 bytes 8-15), write_data; lengths above MAX_PATTERN saturate
//   throughput: one chunk per cycle while result is not held; all CHUNK_BYTES
//           offset lanes compare in parallel in the cycle of the transfer, so
//           the rate is set by the single registered merge stage
//   reset: empties the output register and the skid entry, length goes to 1,
//           pattern to zero
//   stall: a held result keeps the output register; one more chunk is taken
//           into a skid entry, then chunk.ready drops until result drains
module chunk_pattern_match #(
    parameter int CHUNK_BYTES = 8,
    parameter int MAX_PATTERN = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          write_enable,
    input  logic [cpm_pkg::IDX_W-1:0]     write_index,
    input  logic [cpm_pkg::DATA_W-1:0]    write_data,
    cpm_chunk_if.sink                     chunk,
    cpm_result_if.source                  result
);

    logic [cpm_pkg::LEN_W-1:0]  pattern_length_reg;
    logic [cpm_pkg::DATA_W-1:0] pattern_low_reg;
    logic [cpm_pkg::DATA_W-1:0] pattern_high_reg;
    cpm_pkg::cpm_byte_t         pattern [MAX_PATTERN];
    logic [CHUNK_BYTES-1:0]     hits;
    cpm_pkg::cpm_pass_t         pass;
    logic                       room;
    logic                       take;
    logic [cpm_pkg::LEN_W-1:0]  len_sat;

    assign len_sat = (write_data[cpm_pkg::LEN_W-1:0] > cpm_pkg::LEN_W'(MAX_PATTERN))
                   ? cpm_pkg::LEN_W'(MAX_PATTERN) : write_data[cpm_pkg::LEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= cpm_pkg::LEN_W'(1);
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
        end
        else if (write_enable)
        begin
            unique case (cpm_pkg::cpm_cfg_index_t'(write_index))
                cpm_pkg::CFG_PATTERN_LENGTH: pattern_length_reg <= len_sat;
                cpm_pkg::CFG_PATTERN_LOW:    pattern_low_reg    <= write_data;
                cpm_pkg::CFG_PATTERN_HIGH:   pattern_high_reg   <= write_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic [2:0] b;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            b = 3'(j);
            if (j < cpm_pkg::WORD_BYTES)
                pattern[j] = pattern_low_reg[{b, 3'b000} +: 8];
            else
                pattern[j] = pattern_high_reg[{b, 3'b000} +: 8];
        end
    end

    for (genvar i = 0; i < CHUNK_BYTES; i++)
    begin : g_lane
        cpm_lane #(
            .LANE        (i),
            .CHUNK_BYTES (CHUNK_BYTES),
            .MAX_PATTERN (MAX_PATTERN)
        ) u_lane (
            .text_bytes (chunk.text_bytes),
            .pattern    (pattern),
            .length     (pattern_length_reg),
            .hit        (hits[i])
        );
    end

    assign pass.row    = chunk.row_number;
    assign pass.eop    = chunk.end_of_packet;
    assign chunk.ready = room;
    assign take        = chunk.valid && room;

    cpm_merge #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .hits   (hits),
        .pass   (pass),
        .take   (take),
        .room   (room),
        .result (result)
    );

endmodule

[src/cpm_checker.sv]
// cpm_checker: port-level assertions for chunk_pattern_match
// depends on cpm_pkg; bound to the top level below
module cpm_checker #(
    parameter int CHUNK_BYTES = 8
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          chunk_valid,
    input logic                          chunk_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [cpm_pkg::MASK_W-1:0]    match_mask
);

    // held result stays offered
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // back-pressure only when a result is waiting
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !chunk_ready |-> result_valid)
        else $error("chunk stalled with no result pending");

    // a transfer into an empty block shows a result next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_valid && chunk_ready && !result_valid |=> result_valid)
        else $error("result missing one cycle after transfer");

    // no offsets beyond the chunk
    a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((match_mask >> CHUNK_BYTES) == '0))
        else $error("match bit beyond chunk");

endmodule

bind chunk_pattern_match cpm_checker #(
    .CHUNK_BYTES (CHUNK_BYTES)
) u_cpm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .chunk_valid  (chunk.valid),
    .chunk_ready  (chunk.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .match_mask   (result.match_mask)
);
